>>> hdl/audio_frame_header_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Audio frame header parser assertion macros
// Shared helpers for the concurrent checks of the header parser.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_HEADER_PARSER_UNIT_DEFINES_SVH
`define AUDIO_FRAME_HEADER_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFHP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/afhp_pkg.sv
// ----------------------------------------------------------------------------
// Audio frame header parser package
// Stage types, header codes and constant lookup tables shared by the parser.
// ----------------------------------------------------------------------------
package afhp_pkg;

    localparam logic [1:0] VER_25      = 2'd0;
    localparam logic [1:0] VER_RSVD    = 2'd1;
    localparam logic [1:0] VER_2       = 2'd2;
    localparam logic [1:0] VER_1       = 2'd3;
    localparam logic [1:0] LAYER_III   = 2'd1;
    localparam logic [1:0] RTI_44K     = 2'd0;
    localparam logic [1:0] RTI_48K     = 2'd1;
    localparam logic [1:0] RTI_32K     = 2'd2;
    localparam logic [1:0] RTI_RSVD    = 2'd3;
    localparam logic [3:0] BRI_FREE    = 4'd0;
    localparam logic [3:0] BRI_BAD     = 4'd15;
    localparam logic [1:0] MODE_MONO   = 2'd3;
    localparam logic [3:0] ADTS_RTI_LIM = 4'd13;

    localparam logic [10:0] NUM_SCALE  = 11'd1440;
    localparam logic [8:0]  DIV_D      = 9'd441;
    localparam logic [11:0] DIV_RECIP  = 12'd2377;
    localparam int          DIV_SHIFT  = 20;

    typedef struct packed {
        logic        ok;
        logic        is_mpeg;
        logic        use_div;
        logic        pad;
        logic [18:0] num;
        logic [12:0] base_len;
        logic [12:0] samples;
        logic [16:0] rate;
        logic [1:0]  chans;
    } t_stage;

    typedef struct packed {
        logic        valid;
        logic [12:0] frame_len;
        logic [12:0] samples;
        logic [16:0] rate;
        logic [1:0]  chans;
    } t_result;

    function automatic logic [8:0] mp_kbps(input logic v1, input logic [3:0] bri);
        logic [8:0] k;
        if (v1) begin
            case (bri)
                4'd1:    k = 9'd32;
                4'd2:    k = 9'd40;
                4'd3:    k = 9'd48;
                4'd4:    k = 9'd56;
                4'd5:    k = 9'd64;
                4'd6:    k = 9'd80;
                4'd7:    k = 9'd96;
                4'd8:    k = 9'd112;
                4'd9:    k = 9'd128;
                4'd10:   k = 9'd160;
                4'd11:   k = 9'd192;
                4'd12:   k = 9'd224;
                4'd13:   k = 9'd256;
                4'd14:   k = 9'd320;
                default: k = 9'd0;
            endcase
        end else begin
            case (bri)
                4'd1:    k = 9'd8;
                4'd2:    k = 9'd16;
                4'd3:    k = 9'd24;
                4'd4:    k = 9'd32;
                4'd5:    k = 9'd40;
                4'd6:    k = 9'd48;
                4'd7:    k = 9'd56;
                4'd8:    k = 9'd64;
                4'd9:    k = 9'd80;
                4'd10:   k = 9'd96;
                4'd11:   k = 9'd112;
                4'd12:   k = 9'd128;
                4'd13:   k = 9'd144;
                4'd14:   k = 9'd160;
                default: k = 9'd0;
            endcase
        end
        return k;
    endfunction

    function automatic logic [16:0] mp_rate(input logic [1:0] ver, input logic [1:0] rti);
        logic [16:0] r;
        r = 17'd0;
        case (ver)
            VER_1: begin
                case (rti)
                    RTI_44K: r = 17'd44100;
                    RTI_48K: r = 17'd48000;
                    RTI_32K: r = 17'd32000;
                    default: r = 17'd0;
                endcase
            end
            VER_2: begin
                case (rti)
                    RTI_44K: r = 17'd22050;
                    RTI_48K: r = 17'd24000;
                    RTI_32K: r = 17'd16000;
                    default: r = 17'd0;
                endcase
            end
            VER_25: begin
                case (rti)
                    RTI_44K: r = 17'd11025;
                    RTI_48K: r = 17'd12000;
                    RTI_32K: r = 17'd8000;
                    default: r = 17'd0;
                endcase
            end
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] adts_rate(input logic [3:0] rti);
        logic [16:0] r;
        case (rti)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            4'd12:   r = 17'd7350;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/afhp_decode.sv
// ----------------------------------------------------------------------------
// Audio frame header parser decode stage
// Checks the header fields for the selected codec and prepares the length.
// ----------------------------------------------------------------------------
module afhp_decode (
    input  logic [55:0]     i_bytes,
    input  logic            i_codec_is_aac,
    output afhp_pkg::t_stage o_stage
);
    import afhp_pkg::*;

    logic [7:0]  b0, b1, b2, b3, b4, b5, b6;
    logic [1:0]  ver, lay, rti;
    logic [3:0]  bri, arti;
    logic        v1, mp_ok, ad_ok;
    logic [8:0]  kbps, m;
    logic [19:0] num_full;
    logic [11:0] m9;
    logic [10:0] m3;
    logic [10:0] exact;
    logic [2:0]  ach;
    logic [12:0] alen;
    logic [12:0] amin;
    logic [2:0]  blocks;

    assign b0 = i_bytes[7:0];
    assign b1 = i_bytes[15:8];
    assign b2 = i_bytes[23:16];
    assign b3 = i_bytes[31:24];
    assign b4 = i_bytes[39:32];
    assign b5 = i_bytes[47:40];
    assign b6 = i_bytes[55:48];

    assign ver = b1[4:3];
    assign lay = b1[2:1];
    assign bri = b2[7:4];
    assign rti = b2[3:2];
    assign v1  = (ver == VER_1);

    assign kbps     = mp_kbps(v1, bri);
    assign m        = (ver == VER_25) ? {kbps[7:0], 1'b0} : kbps;
    assign num_full = 20'(m) * 20'(NUM_SCALE);
    assign m9       = 12'(m) * 12'd9;
    assign m3       = 11'(m) * 11'd3;
    assign exact    = (rti == RTI_48K) ? m3 : m9[11:1];

    assign mp_ok = (b0 == 8'hFF) && ((b1 & 8'hE0) == 8'hE0) && (ver != VER_RSVD)
                && (lay == LAYER_III) && (bri != BRI_FREE) && (bri != BRI_BAD)
                && (rti != RTI_RSVD);

    assign arti   = b2[5:2];
    assign ach    = {b2[0], b3[7:6]};
    assign alen   = {b3[1:0], b4, b5[7:5]};
    assign amin   = b1[0] ? 13'd7 : 13'd9;
    assign blocks = {1'b0, b6[1:0]} + 3'd1;
    assign ad_ok  = (b0 == 8'hFF) && ((b1 & 8'hF6) == 8'hF0) && (arti < ADTS_RTI_LIM)
                 && ((ach == 3'd1) || (ach == 3'd2)) && (alen >= amin);

    always_comb begin
        if (i_codec_is_aac) begin
            o_stage.ok       = ad_ok;
            o_stage.is_mpeg  = 1'b0;
            o_stage.use_div  = 1'b0;
            o_stage.pad      = 1'b0;
            o_stage.num      = 19'd0;
            o_stage.base_len = alen;
            o_stage.samples  = {blocks, 10'd0};
            o_stage.rate     = adts_rate(arti);
            o_stage.chans    = ach[1:0];
        end else begin
            o_stage.ok       = mp_ok;
            o_stage.is_mpeg  = 1'b1;
            o_stage.use_div  = (rti == RTI_44K);
            o_stage.pad      = b2[1];
            o_stage.num      = num_full[18:0];
            o_stage.base_len = {2'b00, exact};
            o_stage.samples  = v1 ? 13'd1152 : 13'd576;
            o_stage.rate     = mp_rate(ver, rti);
            o_stage.chans    = (b3[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
        end
    end

endmodule

>>> hdl/afhp_div441.sv
// ----------------------------------------------------------------------------
// Audio frame header parser constant divider
// Two-stage reciprocal estimate of a quotient by 441 and its back product.
// ----------------------------------------------------------------------------
module afhp_div441 (
    input  logic        i_clk,
    input  logic        i_en2,
    input  logic        i_en3,
    input  logic [18:0] i_num,
    output logic [10:0] o_q,
    output logic [19:0] o_t
);
    import afhp_pkg::*;

    logic [30:0] r_prod;
    logic [10:0] r_q;
    logic [19:0] r_t;
    logic [10:0] n_q;
    logic [19:0] n_t;

    assign n_q = r_prod[DIV_SHIFT+10:DIV_SHIFT];
    assign n_t = 20'(n_q) * 20'(DIV_D);

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_prod <= 31'(i_num) * 31'(DIV_RECIP);
        end
        if (i_en3) begin
            r_q <= n_q;
            r_t <= n_t;
        end
    end

    assign o_q = r_q;
    assign o_t = r_t;

endmodule

>>> hdl/afhp_finish.sv
// ----------------------------------------------------------------------------
// Audio frame header parser finishing stage
// Corrects the quotient, adds padding and zeroes the fields of a bad header.
// ----------------------------------------------------------------------------
module afhp_finish (
    input  afhp_pkg::t_stage  i_stage,
    input  logic [10:0]       i_q,
    input  logic [19:0]       i_t,
    output afhp_pkg::t_result o_res
);
    import afhp_pkg::*;

    logic [18:0] diff;
    logic        corr;
    logic [10:0] q;
    logic [12:0] base;
    logic [12:0] flen;
    logic        good;

    assign diff = i_stage.num - i_t[18:0];
    assign corr = (diff >= 19'(DIV_D));
    assign q    = i_q + 11'(corr);
    assign base = i_stage.use_div ? {2'b00, q} : i_stage.base_len;
    assign flen = base + 13'(i_stage.pad);
    assign good = i_stage.ok && (!i_stage.is_mpeg || (flen > 13'd4));

    always_comb begin
        o_res.valid     = good;
        o_res.frame_len = good ? flen : 13'd0;
        o_res.samples   = good ? i_stage.samples : 13'd0;
        o_res.rate      = good ? i_stage.rate : 17'd0;
        o_res.chans     = good ? i_stage.chans : 2'd0;
    end

endmodule

>>> hdl/audio_frame_header_parser_unit.sv
// ----------------------------------------------------------------------------
// Audio frame header parser
// Parses an MPEG Layer III or ADTS header candidate in a four-stage pipeline.
// ----------------------------------------------------------------------------
// The slave stream carries seven header bytes per request, byte 0 lowest.
// The master stream returns one result per request: tuser is the valid flag
// and tdata holds frame length, samples per frame, sample rate and channels.
// All result fields are zero for a header that fails a check.
// The codec register is written through i_cfg_we and i_cfg_wdata; the user
// must write it only while the pipeline is empty; the block does not enforce.
// 0 selects MPEG Layer III and 1 selects ADTS.
// One request is taken every cycle while the master side does not stall.
// The four stages are decode, reciprocal multiply, back multiply and
// correction; the multiplier stages set the depth.
// Each stage holds while its successor is full and stalled, so a stalled
// receiver first fills the empty stages and only then drops s_axis_tready.
// Reset empties the pipeline and selects MPEG Layer III.
// ----------------------------------------------------------------------------
`include "audio_frame_header_parser_unit_defines.svh"

module audio_frame_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // header_byte0 .. header_byte6 from the lowest bit up
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // frame_len, samples_per_frame, sample_rate_hz, channel_count, zero fill
    output logic [47:0] m_axis_tdata,
    // header_valid
    output logic        m_axis_tuser
);
    import afhp_pkg::*;

    logic    r_codec;
    logic    r_v1, r_v2, r_v3, r_v4;
    logic    en1, en2, en3, en4;
    t_stage  n_s1, r_s1, r_s2, r_s3;
    t_result n_out, r_out;
    logic [10:0] w_q;
    logic [19:0] w_t;

    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_codec <= i_cfg_wdata;
            end
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    afhp_decode u_decode (
        .i_bytes        (s_axis_tdata),
        .i_codec_is_aac (r_codec),
        .o_stage        (n_s1)
    );

    afhp_div441 u_div (
        .i_clk (i_clk),
        .i_en2 (en2),
        .i_en3 (en3),
        .i_num (r_s1.num),
        .o_q   (w_q),
        .o_t   (w_t)
    );

    afhp_finish u_finish (
        .i_stage (r_s3),
        .i_q     (w_q),
        .i_t     (w_t),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2 <= r_s1;
        end
        if (en3) begin
            r_s3 <= r_s2;
        end
        if (en4) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tuser  = r_out.valid;
    assign m_axis_tdata  = {3'b000, r_out.chans, r_out.rate, r_out.samples,
                            r_out.frame_len};

    `AFHP_ASSERT_SAME(a_inv_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 48'd0,
        "Rejected header carries non-zero result fields.")
    `AFHP_ASSERT_SAME(a_good_fields, m_axis_tvalid && m_axis_tuser,
        (m_axis_tdata[44:43] != 2'd0) && (m_axis_tdata[12:0] > 13'd4)
        && (m_axis_tdata[42:26] != 17'd0),
        "Accepted header has an empty channel count, rate or length.")
    `AFHP_ASSERT_SAME(a_div_low, r_v3 && r_s3.use_div, w_t <= {1'b0, r_s3.num},
        "Quotient estimate by 441 exceeds the true quotient.")
    `AFHP_ASSERT_SAME(a_full_stall, r_v1 && r_v2 && r_v3 && r_v4 && !m_axis_tready,
        !s_axis_tready, "Full pipeline took a request under a stall.")
    `AFHP_ASSERT_NEXT(a_s1_fill, s_axis_tvalid && s_axis_tready, r_v1,
        "Accepted request did not enter the decode stage.")

endmodule
